FILE: hw/rtl/forth_stack_alu_top_macros.svh
// Assertion macros shared by the forth_stack_alu RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef FORTH_STACK_ALU_TOP_MACROS_SVH
`define FORTH_STACK_ALU_TOP_MACROS_SVH

// same-cycle implication, masked during reset
`define FSA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("forth_stack_alu: assertion failed");

// next-cycle implication, masked during reset
`define FSA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("forth_stack_alu: assertion failed");

`endif

FILE: hw/rtl/fsa_pkg.sv
// Shared types and constants for the forth_stack_alu block.
// No dependencies.
package fsa_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned CELL_W          = 32;
	localparam int unsigned OPC_W           = 4;
	localparam int unsigned DEPTH_W         = 7;
	localparam int unsigned QUEUE_DEPTH     = 2;

	typedef logic [CELL_W-1:0] cell_t;

	typedef enum logic [OPC_W-1:0] {
		OP_LIT   = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_DUP   = 4'd5,
		OP_DROP  = 4'd6,
		OP_SWAP  = 4'd7,
		OP_OVER  = 4'd8,
		OP_PRINT = 4'd9,
		OP_NOP   = 4'd15
	} op_t;

	typedef struct packed {
		op_t   op;
		logic  binary;
		cell_t lit;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: hw/rtl/fsa_front.sv
// Front end: accept a word beat, decode and register it for the queue.
// Depends on fsa_pkg.
module fsa_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  logic [fsa_pkg::OPC_W-1:0]  operation,
	input  logic signed [fsa_pkg::CELL_W-1:0] literal,
	output logic                       valid_s1,
	output fsa_pkg::cmd_t              cmd_s1,
	input  logic                       take
);
	import fsa_pkg::*;

	op_t  dec_op;
	logic accept;

	assign cmd_ready = !valid_s1 || take;
	assign accept    = cmd_valid && cmd_ready;

	always_comb begin
		if (operation <= OPC_W'(OP_PRINT)) begin
			dec_op = op_t'(operation);
		end else begin
			dec_op = OP_NOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op     <= dec_op;
			cmd_s1.binary <= dec_op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
			cmd_s1.lit    <= cell_t'(literal);
		end
	end

endmodule

FILE: hw/rtl/fsa_queue.sv
// Short command queue between the front end and the execute back end.
// Depends on fsa_pkg and the assertion macro header.
`include "forth_stack_alu_top_macros.svh"
module fsa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fsa_pkg::cmd_t in_cmd,
	output logic          out_valid,
	output fsa_pkg::cmd_t out_cmd,
	input  logic          pop
);
	import fsa_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          ent_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;
	logic          push;

	assign in_ready  = cnt_q != NW'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign out_cmd   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_cmd;
		end
	end

	`FSA_ASSERT_IMP(a_q_pop_nonempty, pop, out_valid)
	`FSA_ASSERT_NXT(a_q_push_holds, push && !pop, cnt_q != '0)

endmodule

FILE: hw/rtl/fsa_div.sv
// Bit-serial restoring divider on magnitudes, one quotient bit per cycle.
// Depends on fsa_pkg.
module fsa_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fsa_pkg::cell_t    dividend,
	input  fsa_pkg::cell_t    divisor,
	output fsa_pkg::cell_t    quotient,
	output fsa_pkg::div_stat_t stat
);
	import fsa_pkg::*;

	localparam int unsigned KW = $clog2(CELL_W + 1);

	cell_t         quo_q;
	cell_t         rem_q;
	cell_t         dvs_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [CELL_W:0] sh;
	logic [CELL_W:0] diff;
	logic          ge;

	assign sh       = {rem_q, quo_q[CELL_W-1]};
	assign diff     = sh - {1'b0, dvs_q};
	assign ge       = !diff[CELL_W];
	assign quotient = quo_q;
	assign stat     = '{busy: busy_q, done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= KW'(CELL_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - KW'(1);
			if (cnt_q == KW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[CELL_W-2:0], ge};
			rem_q <= ge ? diff[CELL_W-1:0] : sh[CELL_W-1:0];
		end
	end

endmodule

FILE: hw/rtl/fsa_back.sv
// Execute back end: top two cells in registers, deeper cells in a memory.
// Depends on fsa_pkg, fsa_div (by ports) and the assertion macro header.
`include "forth_stack_alu_top_macros.svh"
module fsa_back #(
	parameter int unsigned STACK_DEPTH = fsa_pkg::STACK_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  fsa_pkg::cmd_t             cmd,
	output logic                      cmd_pop,
	output logic                      div_start,
	output fsa_pkg::cell_t            div_a,
	output fsa_pkg::cell_t            div_b,
	input  fsa_pkg::cell_t            div_q,
	input  fsa_pkg::div_stat_t        div_stat,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic signed [fsa_pkg::CELL_W-1:0]  top_value,
	output logic [fsa_pkg::DEPTH_W-1:0]        depth,
	output logic                      printed_valid,
	output logic signed [fsa_pkg::CELL_W-1:0]  printed_value,
	output logic                      overflow_flag,
	output logic                      underflow_flag,
	output logic                      divide_by_zero_flag
);
	import fsa_pkg::*;

	localparam int unsigned CW        = $clog2(STACK_DEPTH + 1);
	localparam int unsigned MEM_DEPTH = (STACK_DEPTH > 2) ? STACK_DEPTH - 2 : 1;
	localparam int unsigned AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	typedef enum logic [1:0] {S_IDLE, S_SETTLE, S_DIV} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	cell_t         t0_q;
	cell_t         t1_q;
	cell_t         rd_q;
	cell_t         mem [MEM_DEPTH];

	logic          ge1, ge2, ge3, full;
	cell_t         opa, opb, quot, alu_r;
	logic          neg, dz, out_free, apply;
	logic [AW-1:0] wr_addr, rd_addr;

	logic [CW-1:0] nxt_cnt;
	cell_t         nxt_t0, nxt_t1;
	logic          wr_en, ov, un, pv;
	cell_t         pval;

	assign ge1  = cnt_q != '0;
	assign ge2  = cnt_q >= CW'(2);
	assign ge3  = cnt_q >= CW'(3);
	assign full = cnt_q == CW'(STACK_DEPTH);

	assign opb   = ge1 ? t0_q : '0;
	assign opa   = ge2 ? t1_q : '0;
	assign dz    = opb == '0;
	assign neg   = opa[CELL_W-1] ^ opb[CELL_W-1];
	assign div_a = opa[CELL_W-1] ? -opa : opa;
	assign div_b = opb[CELL_W-1] ? -opb : opb;
	assign quot  = neg ? -div_q : div_q;

	assign out_free  = !res_valid || res_ready;
	assign div_start = (state_q == S_IDLE) && cmd_valid && (cmd.op == OP_DIV) && !dz;
	assign apply     = out_free && cmd_valid &&
		(((state_q == S_IDLE) && ((cmd.op != OP_DIV) || dz)) ||
		((state_q == S_DIV) && div_stat.done));
	assign cmd_pop   = apply;

	assign wr_addr = AW'(cnt_q - CW'(2));
	assign rd_addr = ge3 ? AW'(cnt_q - CW'(3)) : '0;

	always_comb begin
		case (cmd.op)
			OP_ADD:  alu_r = opa + opb;
			OP_SUB:  alu_r = opa - opb;
			OP_MUL:  alu_r = opa * opb;
			OP_DIV:  alu_r = dz ? '0 : quot;
			default: alu_r = '0;
		endcase
	end

	always_comb begin
		nxt_cnt = cnt_q;
		nxt_t0  = t0_q;
		nxt_t1  = t1_q;
		wr_en   = 1'b0;
		ov      = 1'b0;
		un      = 1'b0;
		pv      = 1'b0;
		pval    = '0;
		if (cmd.binary) begin
			nxt_t0 = alu_r;
			if (ge2) begin
				nxt_t1  = rd_q;
				nxt_cnt = cnt_q - CW'(1);
			end else begin
				un = 1'b1;
				if (!ge1) begin
					nxt_cnt = CW'(1);
				end
			end
		end else begin
			case (cmd.op)
				OP_LIT: begin
					if (full) begin
						ov = 1'b1;
					end else begin
						wr_en   = ge2;
						nxt_t1  = t0_q;
						nxt_t0  = cmd.lit;
						nxt_cnt = cnt_q + CW'(1);
					end
				end
				OP_DUP: begin
					if (!ge1) begin
						un      = 1'b1;
						nxt_t0  = '0;
						nxt_t1  = '0;
						nxt_cnt = CW'(2);
					end else if (full) begin
						ov = 1'b1;
					end else begin
						wr_en   = ge2;
						nxt_t1  = t0_q;
						nxt_cnt = cnt_q + CW'(1);
					end
				end
				OP_DROP, OP_PRINT: begin
					if (!ge1) begin
						un = 1'b1;
					end else begin
						pv      = cmd.op == OP_PRINT;
						pval    = (cmd.op == OP_PRINT) ? t0_q : '0;
						nxt_t0  = t1_q;
						nxt_t1  = rd_q;
						nxt_cnt = cnt_q - CW'(1);
					end
				end
				OP_SWAP: begin
					if (ge2) begin
						nxt_t0 = t1_q;
						nxt_t1 = t0_q;
					end else begin
						un      = 1'b1;
						nxt_t0  = '0;
						nxt_t1  = opb;
						nxt_cnt = CW'(2);
					end
				end
				OP_OVER: begin
					if (!ge2) begin
						un = 1'b1;
					end else if (full) begin
						ov = 1'b1;
					end else begin
						wr_en   = 1'b1;
						nxt_t0  = t1_q;
						nxt_t1  = t0_q;
						nxt_cnt = cnt_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= S_IDLE;
			cnt_q               <= '0;
			res_valid           <= 1'b0;
			top_value           <= '0;
			depth               <= '0;
			printed_valid       <= 1'b0;
			printed_value       <= '0;
			overflow_flag       <= 1'b0;
			underflow_flag      <= 1'b0;
			divide_by_zero_flag <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				res_valid <= 1'b0;
			end
			if (apply) begin
				res_valid           <= 1'b1;
				cnt_q               <= nxt_cnt;
				top_value           <= (nxt_cnt != '0) ? nxt_t0 : '0;
				depth               <= DEPTH_W'(nxt_cnt);
				printed_valid       <= pv;
				printed_value       <= pval;
				overflow_flag       <= ov;
				underflow_flag      <= un;
				divide_by_zero_flag <= (cmd.op == OP_DIV) && dz;
			end
			case (state_q)
				S_IDLE: begin
					if (apply) begin
						state_q <= S_SETTLE;
					end else if (div_start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (apply) begin
						state_q <= S_SETTLE;
					end
				end
				S_SETTLE: state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			t0_q <= nxt_t0;
			t1_q <= nxt_t1;
		end
	end

	always_ff @(posedge clk) begin
		if (apply && wr_en) begin
			mem[wr_addr] <= t1_q;
		end
		rd_q <= mem[rd_addr];
	end

	`FSA_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(STACK_DEPTH))
	`FSA_ASSERT_NXT(a_apply_result, apply, res_valid)
	`FSA_ASSERT_IMP(a_div_tracked, state_q == S_DIV, div_stat.busy || div_stat.done)

endmodule

FILE: hw/rtl/forth_stack_alu_top.sv
// Forth data-stack ALU: a front end decodes each word beat into a short queue, and
// the back end executes it on a bounded stack of signed 32-bit cells. Most words pass
// through an execute state and a settle state in the back end, the settle state covering
// the registered read of the third cell from the stack memory. A divide by a nonzero
// divisor executes from a divide state once the bit-serial divider, which produces one
// quotient bit per cycle, is done; a divide by zero executes like the other words. The
// queue lets the next word be accepted while a result beat waits. No clearing pass after reset.
module forth_stack_alu_top #(
	parameter int unsigned STACK_DEPTH = fsa_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  logic [fsa_pkg::OPC_W-1:0]          operation,
	input  logic signed [fsa_pkg::CELL_W-1:0]  literal,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [fsa_pkg::CELL_W-1:0]  top_value,
	output logic [fsa_pkg::DEPTH_W-1:0]        depth,
	output logic                               printed_valid,
	output logic signed [fsa_pkg::CELL_W-1:0]  printed_value,
	output logic                               overflow_flag,
	output logic                               underflow_flag,
	output logic                               divide_by_zero_flag
);
	import fsa_pkg::*;

	logic      valid_s1;
	cmd_t      cmd_s1;
	logic      q_ready;
	logic      q_valid;
	cmd_t      q_cmd;
	logic      q_pop;
	logic      div_start;
	cell_t     div_a;
	cell_t     div_b;
	cell_t     div_q;
	div_stat_t div_stat;

	fsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.operation (operation),
		.literal   (literal),
		.valid_s1  (valid_s1),
		.cmd_s1    (cmd_s1),
		.take      (q_ready)
	);

	fsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (q_ready),
		.in_cmd    (cmd_s1),
		.out_valid (q_valid),
		.out_cmd   (q_cmd),
		.pop       (q_pop)
	);

	fsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (div_q),
		.stat     (div_stat)
	);

	fsa_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd_valid           (q_valid),
		.cmd                 (q_cmd),
		.cmd_pop             (q_pop),
		.div_start           (div_start),
		.div_a               (div_a),
		.div_b               (div_b),
		.div_q               (div_q),
		.div_stat            (div_stat),
		.res_valid           (res_valid),
		.res_ready           (res_ready),
		.top_value           (top_value),
		.depth               (depth),
		.printed_valid       (printed_valid),
		.printed_value       (printed_value),
		.overflow_flag       (overflow_flag),
		.underflow_flag      (underflow_flag),
		.divide_by_zero_flag (divide_by_zero_flag)
	);

endmodule
